[rtl/hhd_pkg.sv]
`default_nettype none

package hhd_pkg;

	localparam int SYM_W          = 7;
	localparam int BYTE_W         = 8;
	localparam int WIN_W          = 40;
	localparam int CNT_W          = 6;
	localparam int LEN_W          = 5;
	localparam int CODE_W         = 30;
	localparam int STORED_ENTRIES = 128;
	localparam int TABLE_ENTRIES  = 128;
	localparam int ERROR_BITS     = 30;
	localparam int MAX_RESULTS    = 3;
	localparam int NUM_W          = 2;
	localparam int QUEUE_DEPTH    = 2;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              last_of_string;
	} in_word_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             decode_error;
		logic             last_result;
	} out_word_t;

	typedef struct packed {
		logic             hit;
		logic [SYM_W-1:0] index;
		logic [LEN_W-1:0] len;
	} match_t;

	typedef enum logic [0:0] {
		ST_LOAD,
		ST_SCAN
	} eng_state_t;

	// Codes of symbols 0..127, right-aligned
	localparam logic [CODE_W-1:0] CODE_BITS [STORED_ENTRIES] = '{
		30'h1ff8, 30'h7fffd8, 30'hfffffe2, 30'hfffffe3,
		30'hfffffe4, 30'hfffffe5, 30'hfffffe6, 30'hfffffe7,
		30'hfffffe8, 30'hffffea, 30'h3ffffffc, 30'hfffffe9,
		30'hfffffea, 30'h3ffffffd, 30'hfffffeb, 30'hfffffec,
		30'hfffffed, 30'hfffffee, 30'hfffffef, 30'hffffff0,
		30'hffffff1, 30'hffffff2, 30'h3ffffffe, 30'hffffff3,
		30'hffffff4, 30'hffffff5, 30'hffffff6, 30'hffffff7,
		30'hffffff8, 30'hffffff9, 30'hffffffa, 30'hffffffb,
		30'h14, 30'h3f8, 30'h3f9, 30'hffa, 30'h1ff9, 30'h15, 30'hf8, 30'h7fa,
		30'h3fa, 30'h3fb, 30'hf9, 30'h7fb, 30'hfa, 30'h16, 30'h17, 30'h18,
		30'h0, 30'h1, 30'h2, 30'h19, 30'h1a, 30'h1b, 30'h1c, 30'h1d,
		30'h1e, 30'h1f, 30'h5c, 30'hfb, 30'h7ffc, 30'h20, 30'hffb, 30'h3fc,
		30'h1ffa, 30'h21, 30'h5d, 30'h5e, 30'h5f, 30'h60, 30'h61, 30'h62,
		30'h63, 30'h64, 30'h65, 30'h66, 30'h67, 30'h68, 30'h69, 30'h6a,
		30'h6b, 30'h6c, 30'h6d, 30'h6e, 30'h6f, 30'h70, 30'h71, 30'h72,
		30'hfc, 30'h73, 30'hfd, 30'h1ffb, 30'h7fff0, 30'h1ffc, 30'h3ffc, 30'h22,
		30'h7ffd, 30'h3, 30'h23, 30'h4, 30'h24, 30'h5, 30'h25, 30'h26,
		30'h27, 30'h6, 30'h74, 30'h75, 30'h28, 30'h29, 30'h2a, 30'h7,
		30'h2b, 30'h76, 30'h2c, 30'h8, 30'h9, 30'h2d, 30'h77, 30'h78,
		30'h79, 30'h7a, 30'h7b, 30'h7ffe, 30'h7fc, 30'h3ffd, 30'h1ffd, 30'hffffffc
	};

	localparam logic [LEN_W-1:0] CODE_LEN [STORED_ENTRIES] = '{
		5'd13, 5'd23, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28,
		5'd28, 5'd24, 5'd30, 5'd28, 5'd28, 5'd30, 5'd28, 5'd28,
		5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd30, 5'd28,
		5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28,
		5'd6, 5'd10, 5'd10, 5'd12, 5'd13, 5'd6, 5'd8, 5'd11,
		5'd10, 5'd10, 5'd8, 5'd11, 5'd8, 5'd6, 5'd6, 5'd6,
		5'd5, 5'd5, 5'd5, 5'd6, 5'd6, 5'd6, 5'd6, 5'd6,
		5'd6, 5'd6, 5'd7, 5'd8, 5'd15, 5'd6, 5'd12, 5'd10,
		5'd13, 5'd6, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
		5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
		5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
		5'd8, 5'd7, 5'd8, 5'd13, 5'd19, 5'd13, 5'd14, 5'd6,
		5'd15, 5'd5, 5'd6, 5'd5, 5'd6, 5'd5, 5'd6, 5'd6,
		5'd6, 5'd5, 5'd7, 5'd7, 5'd6, 5'd6, 5'd6, 5'd5,
		5'd6, 5'd7, 5'd6, 5'd5, 5'd5, 5'd6, 5'd7, 5'd7,
		5'd7, 5'd7, 5'd7, 5'd15, 5'd11, 5'd14, 5'd13, 5'd28
	};

endpackage

`default_nettype wire

[rtl/hhd_ifs.sv]
`default_nettype none

interface hhd_in_if
	import hhd_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              last_of_string;

	modport source (output valid, output data_byte, output last_of_string, input ready);
	modport sink (input valid, input data_byte, input last_of_string, output ready);
endinterface

interface hhd_out_if
	import hhd_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol;
	logic             decode_error;
	logic             last_result;

	modport source (output valid, output symbol, output decode_error, output last_result,
		input ready);
	modport sink (input valid, input symbol, input decode_error, input last_result,
		output ready);
endinterface

`default_nettype wire

[rtl/hpack_huffman_byte_decoder.sv]
`default_nettype none

// HPACK Huffman byte decoder, symbols 0..127 of the static code.
// Channel in: one coded byte per word (data_byte, MSB first) with
//   last_of_string on the final byte of a string.
// Channel out: one decoded symbol per word; decode_error marks a run of
//   30 or more bits that matches no code (symbol 0, buffer cleared), and
//   last_result flags the final word caused by an input byte. A byte that
//   completes no code and flags no error produces no word at all.
// Both channels use valid/ready; a word moves when both are high.
// Inside, a two-word input queue feeds the decode engine, which loads a
// byte into its 40-bit window and then issues the result words one by one,
// each set by the single parallel code match; a finishing byte overlaps
// the load of the next. The first word of a byte passes from the window
// load through the match into the result hold register, then through the
// output queue on its way to out.
// Reset clears the bit buffer, the count, both queues and the engine.
// When the receiver stalls, the two-word output queue fills, the engine
// holds, then the input queue fills and in.ready drops; nothing is lost.

module hpack_huffman_byte_decoder
	import hhd_pkg::*;
#(
	parameter int CODE_TABLE_ENTRIES = TABLE_ENTRIES
) (
	input  wire logic clk,
	input  wire logic arst_n,
	hhd_in_if.sink    in,
	hhd_out_if.source out
);

	in_word_t  in_word;
	in_word_t  q_word;
	logic      q_valid;
	logic      q_pop;
	out_word_t res_word;
	logic      res_valid;
	logic      res_ready;
	out_word_t out_word;

	assign in_word.data_byte      = in.data_byte;
	assign in_word.last_of_string = in.last_of_string;

	// Front: take bytes as they come, decoupled from the engine
	hhd_fifo #(.WIDTH($bits(in_word_t)), .DEPTH(QUEUE_DEPTH)) u_in_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in.valid),
		.push_ready (in.ready),
		.push_data  (in_word),
		.pop_valid  (q_valid),
		.pop_ready  (q_pop),
		.pop_data   (q_word)
	);

	// Back: window, code match and result sequencing
	hhd_engine #(.ENTRIES(CODE_TABLE_ENTRIES)) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_word   (q_word),
		.in_pop    (q_pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_word  (res_word)
	);

	// Output queue: the engine keeps working while a word waits on out
	hhd_fifo #(.WIDTH($bits(out_word_t)), .DEPTH(QUEUE_DEPTH)) u_out_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (res_valid),
		.push_ready (res_ready),
		.push_data  (res_word),
		.pop_valid  (out.valid),
		.pop_ready  (out.ready),
		.pop_data   (out_word)
	);

	assign out.symbol       = out_word.symbol;
	assign out.decode_error = out_word.decode_error;
	assign out.last_result  = out_word.last_result;

endmodule

`default_nettype wire

[rtl/hhd_fifo.sv]
`default_nettype none

module hhd_fifo
	import hhd_pkg::*;
#(
	parameter int WIDTH = 1,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output logic      [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]  mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (fill_q != FILL_W'(DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/hhd_match.sv]
`default_nettype none

module hhd_match
	import hhd_pkg::*;
#(
	parameter int ENTRIES = TABLE_ENTRIES
) (
	input  wire logic [WIN_W-1:0] window,
	input  wire logic [CNT_W-1:0] count,
	output match_t                result
);

	localparam int N_USED = (ENTRIES < STORED_ENTRIES) ? ENTRIES : STORED_ENTRIES;

	logic [N_USED-1:0] hit;

	// Compare each code against the leading bits of the left-aligned window
	for (genvar t = 0; t < N_USED; t++) begin : g_code
		localparam int L = int'(CODE_LEN[t]);
		assign hit[t] = (count >= CNT_W'(L)) &&
			(window[WIN_W-1 -: L] == CODE_BITS[t][L-1:0]);
	end

	// The code is prefix-free, so at most one entry hits
	always_comb begin
		result = '0;
		for (int t = 0; t < N_USED; t++) begin
			if (hit[t]) begin
				result.hit   = 1'b1;
				result.index = result.index | SYM_W'(t);
				result.len   = result.len | CODE_LEN[t];
			end
		end
	end

endmodule

`default_nettype wire

[rtl/hhd_engine.sv]
`default_nettype none

module hhd_engine
	import hhd_pkg::*;
#(
	parameter int ENTRIES = TABLE_ENTRIES
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire in_word_t in_word,
	output logic          in_pop,
	output logic          res_valid,
	input  wire logic     res_ready,
	output out_word_t     res_word
);

	eng_state_t       state_q;
	eng_state_t       state_d;
	logic [WIN_W-1:0] window_q;
	logic [CNT_W-1:0] count_q;
	logic             last_q;
	logic [NUM_W-1:0] num_q;
	logic             hold_v_q;
	logic [SYM_W-1:0] hold_sym_q;
	logic             hold_err_q;

	match_t           m;
	logic             scan;
	logic             can_push;
	logic             do_sym;
	logic             do_err;
	logic             do_fin;
	logic             go;
	logic             load_ok;
	logic [WIN_W-1:0] base_win;
	logic [CNT_W-1:0] base_cnt;
	logic [WIN_W-1:0] app_win;
	logic [CNT_W-1:0] shamt;

	hhd_match #(.ENTRIES(ENTRIES)) u_match (
		.window (window_q),
		.count  (count_q),
		.result (m)
	);

	assign scan     = (state_q == ST_SCAN);
	assign can_push = !hold_v_q || res_ready;
	assign do_sym   = scan && m.hit && (num_q != NUM_W'(MAX_RESULTS));
	assign do_err   = scan && !do_sym && (count_q >= CNT_W'(ERROR_BITS)) &&
		(num_q != NUM_W'(MAX_RESULTS));
	assign do_fin   = scan && !do_sym && !do_err;
	assign go       = scan && can_push;
	assign load_ok  = in_valid && (!scan || (do_fin && go));

	// Buffer as left after the current word: padding dropped on the last one
	always_comb begin
		if (scan && last_q) begin
			base_win = '0;
			base_cnt = '0;
		end else begin
			base_win = window_q;
			base_cnt = count_q;
		end
	end

	assign shamt   = CNT_W'(WIN_W - BYTE_W) - base_cnt;
	assign app_win = base_win | (WIN_W'(in_word.data_byte) << shamt);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (load_ok) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (go && do_fin && !load_ok) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	// Release the held result once the next decision tells whether it closes the word
	always_comb begin
		in_pop                = load_ok;
		res_valid             = hold_v_q && go;
		res_word.symbol       = hold_sym_q;
		res_word.decode_error = hold_err_q;
		res_word.last_result  = do_fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			window_q <= '0;
			count_q  <= '0;
			last_q   <= 1'b0;
			num_q    <= '0;
			hold_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (go && do_sym) begin
				window_q <= window_q << m.len;
				count_q  <= count_q - CNT_W'(m.len);
				num_q    <= num_q + 1'b1;
				hold_v_q <= 1'b1;
			end else if (go && do_err) begin
				window_q <= '0;
				count_q  <= '0;
				num_q    <= num_q + 1'b1;
				hold_v_q <= 1'b1;
			end else if (load_ok) begin
				window_q <= app_win;
				count_q  <= base_cnt + CNT_W'(BYTE_W);
				last_q   <= in_word.last_of_string;
				num_q    <= '0;
				hold_v_q <= 1'b0;
			end else if (go && do_fin) begin
				window_q <= base_win;
				count_q  <= base_cnt;
				hold_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && do_sym) begin
			hold_sym_q <= m.index;
			hold_err_q <= 1'b0;
		end else if (go && do_err) begin
			hold_sym_q <= '0;
			hold_err_q <= 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(ERROR_BITS - 1 + BYTE_W))
		else $error("bit count beyond one byte over the error limit");

	a_idle_short: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> (count_q < CNT_W'(ERROR_BITS)))
		else $error("idle with an undecodable run left in the buffer");

	a_two_symbols: assert property (@(posedge clk) disable iff (!arst_n)
		do_sym |-> (num_q < NUM_W'(2)))
		else $error("third symbol decoded from one byte");

	a_load_count: assert property (@(posedge clk) disable iff (!arst_n)
		in_pop |=> (count_q >= CNT_W'(BYTE_W)))
		else $error("byte load left fewer than eight bits");
`endif

endmodule

`default_nettype wire

[sim/hpack_huffman_byte_decoder_tb.sv]
`default_nettype none

module hpack_huffman_byte_decoder_tb;
	import hhd_pkg::*;

	// Run the block with the full stored table.
	localparam int CODE_TABLE_ENTRIES = 128;
	localparam int HUFF_SYMBOLS       = 128;
	localparam int MIN_CODE_LEN       = 5;
	// A pending run this long that matches nothing cannot be one of our codes.
	localparam int UNMATCHED_LIMIT    = 30;
	localparam int WORDS_PER_BYTE     = 3;
	// A byte may finish inside the block long after the last predicted word
	// has left, so hold on after the drain to let it finish.
	localparam int SETTLE_CYCLES      = 16;
	localparam int CYCLE_LIMIT        = 200000;

	// Receiver behavior on the out channel.
	typedef enum int {
		RX_ALWAYS,
		RX_RANDOM,
		RX_PERIODIC,
		RX_SLOW
	} rx_mode_e;

	// What goes after the last code of a string.
	typedef enum int {
		PAD_ONES,   // proper padding: ones up to the byte boundary
		PAD_LONG,   // ones to the boundary plus a whole extra byte of ones
		PAD_RANDOM, // random bits to the boundary
		PAD_OPEN    // random bits, and the string is never closed
	} pad_mode_e;

	// Static Huffman code, symbols 0..127, right-aligned with lengths.
	localparam logic [31:0] HUFF_CODE [HUFF_SYMBOLS] = '{
		32'h1ff8, 32'h7fffd8, 32'hfffffe2, 32'hfffffe3,
		32'hfffffe4, 32'hfffffe5, 32'hfffffe6, 32'hfffffe7,
		32'hfffffe8, 32'hffffea, 32'h3ffffffc, 32'hfffffe9,
		32'hfffffea, 32'h3ffffffd, 32'hfffffeb, 32'hfffffec,
		32'hfffffed, 32'hfffffee, 32'hfffffef, 32'hffffff0,
		32'hffffff1, 32'hffffff2, 32'h3ffffffe, 32'hffffff3,
		32'hffffff4, 32'hffffff5, 32'hffffff6, 32'hffffff7,
		32'hffffff8, 32'hffffff9, 32'hffffffa, 32'hffffffb,
		32'h14, 32'h3f8, 32'h3f9, 32'hffa, 32'h1ff9, 32'h15, 32'hf8, 32'h7fa,
		32'h3fa, 32'h3fb, 32'hf9, 32'h7fb, 32'hfa, 32'h16, 32'h17, 32'h18,
		32'h0, 32'h1, 32'h2, 32'h19, 32'h1a, 32'h1b, 32'h1c, 32'h1d,
		32'h1e, 32'h1f, 32'h5c, 32'hfb, 32'h7ffc, 32'h20, 32'hffb, 32'h3fc,
		32'h1ffa, 32'h21, 32'h5d, 32'h5e, 32'h5f, 32'h60, 32'h61, 32'h62,
		32'h63, 32'h64, 32'h65, 32'h66, 32'h67, 32'h68, 32'h69, 32'h6a,
		32'h6b, 32'h6c, 32'h6d, 32'h6e, 32'h6f, 32'h70, 32'h71, 32'h72,
		32'hfc, 32'h73, 32'hfd, 32'h1ffb, 32'h7fff0, 32'h1ffc, 32'h3ffc, 32'h22,
		32'h7ffd, 32'h3, 32'h23, 32'h4, 32'h24, 32'h5, 32'h25, 32'h26,
		32'h27, 32'h6, 32'h74, 32'h75, 32'h28, 32'h29, 32'h2a, 32'h7,
		32'h2b, 32'h76, 32'h2c, 32'h8, 32'h9, 32'h2d, 32'h77, 32'h78,
		32'h79, 32'h7a, 32'h7b, 32'h7ffe, 32'h7fc, 32'h3ffd, 32'h1ffd, 32'hffffffc
	};

	localparam int HUFF_LEN [HUFF_SYMBOLS] = '{
		13, 23, 28, 28, 28, 28, 28, 28, 28, 24, 30, 28, 28, 30, 28, 28,
		28, 28, 28, 28, 28, 28, 30, 28, 28, 28, 28, 28, 28, 28, 28, 28,
		6, 10, 10, 12, 13, 6, 8, 11, 10, 10, 8, 11, 8, 6, 6, 6,
		5, 5, 5, 6, 6, 6, 6, 6, 6, 6, 7, 8, 15, 6, 12, 10,
		13, 6, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7,
		7, 7, 7, 7, 7, 7, 7, 7, 8, 7, 8, 13, 19, 13, 14, 6,
		15, 5, 6, 5, 6, 5, 6, 6, 6, 5, 7, 7, 6, 6, 6, 5,
		6, 7, 6, 5, 5, 6, 7, 7, 7, 7, 7, 15, 11, 14, 13, 28
	};

	logic clk;
	logic arst_n;

	hhd_in_if  in_if ();
	hhd_out_if out_if ();

	hpack_huffman_byte_decoder #(
		.CODE_TABLE_ENTRIES(CODE_TABLE_ENTRIES)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.in    (in_if),
		.out   (out_if)
	);

	// Predictor state: pending coded bits, right-aligned, and their number.
	logic [63:0] win_bits = '0;
	int          win_len  = 0;

	// Decoded words still owed by the block, oldest first.
	out_word_t pending_syms[$];

	int       mismatch_count = 0;
	int       cycle_count    = 0;
	int       bytes_sent;
	int       burst_left;
	bit       sender_gaps;
	rx_mode_e rx_mode;

	// Clock: period 2.
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Cycle counter and watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("hpack_huffman_byte_decoder test failed");
			$finish;
		end
	end

	// Receiver: stall on a pattern chosen by the running test.
	always @(posedge clk) begin
		case (rx_mode)
			RX_ALWAYS: out_if.ready <= 1'b1;
			RX_RANDOM: out_if.ready <= ($urandom_range(0, 3) != 0);
			RX_PERIODIC: out_if.ready <= ((cycle_count % 13) < 8);
			default: out_if.ready <= ($urandom_range(0, 4) == 0);
		endcase
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH @%0d: %s", cycle_count, what);
		mismatch_count++;
	endtask

	// Find the code at the head of the pending bits; -1 when none applies.
	function automatic int match_code();
		logic [63:0] head;
		for (int t = 0; t < CODE_TABLE_ENTRIES && t < HUFF_SYMBOLS; t++) begin
			if (HUFF_LEN[t] <= win_len) begin
				head = (win_bits >> (win_len - HUFF_LEN[t])) &
					((64'd1 << HUFF_LEN[t]) - 64'd1);
				if (head == 64'(HUFF_CODE[t]))
					return t;
			end
		end
		return -1;
	endfunction

	// Advance the predictor by one accepted byte and queue the words it owes.
	task automatic decode_byte(input logic [7:0] coded, input logic closes);
		out_word_t step_words[$];
		out_word_t w;
		int        hit;
		win_bits = ((win_bits << 8) | 64'(coded)) & 64'hFF_FFFF_FFFF;
		win_len += 8;
		// Pull complete codes off the head while enough bits are there.
		while (win_len >= MIN_CODE_LEN && step_words.size() < WORDS_PER_BYTE) begin
			hit = match_code();
			if (hit < 0)
				break;
			w.symbol       = SYM_W'(hit);
			w.decode_error = 1'b0;
			w.last_result  = 1'b0;
			step_words.push_back(w);
			win_len -= HUFF_LEN[hit];
			win_bits &= (64'd1 << win_len) - 64'd1;
		end
		// A long run with no code in it: flag an error and drop the run.
		if (win_len >= UNMATCHED_LIMIT && step_words.size() < WORDS_PER_BYTE) begin
			w.symbol       = '0;
			w.decode_error = 1'b1;
			w.last_result  = 1'b0;
			step_words.push_back(w);
			win_bits = '0;
			win_len  = 0;
		end
		// End of string: padding goes, whatever it holds.
		if (closes) begin
			win_bits = '0;
			win_len  = 0;
		end
		if (step_words.size() > 0)
			step_words[step_words.size() - 1].last_result = 1'b1;
		foreach (step_words[k])
			pending_syms.push_back(step_words[k]);
	endtask

	// Predict on every accepted byte, then check every accepted word against
	// the oldest owed one. Prediction goes first so a word can never outrun it.
	always @(posedge clk) begin : check_words
		out_word_t want;
		if (arst_n) begin
			if (in_if.valid && in_if.ready)
				decode_byte(in_if.data_byte, in_if.last_of_string);
			if (out_if.valid && out_if.ready) begin
				if (pending_syms.size() == 0) begin
					report_mismatch($sformatf("unexpected word sym %0d err %0b last %0b",
						out_if.symbol, out_if.decode_error, out_if.last_result));
				end else begin
					want = pending_syms.pop_front();
					if (out_if.symbol !== want.symbol)
						report_mismatch($sformatf("symbol %0d, want %0d",
							out_if.symbol, want.symbol));
					if (out_if.decode_error !== want.decode_error)
						report_mismatch($sformatf("decode_error %0b, want %0b (sym %0d)",
							out_if.decode_error, want.decode_error, want.symbol));
					if (out_if.last_result !== want.last_result)
						report_mismatch($sformatf("last_result %0b, want %0b (sym %0d)",
							out_if.last_result, want.last_result, want.symbol));
				end
			end
		end
	end

	// Offer one byte and hold it until the block takes it. The sender runs in
	// bursts; at the end of a burst, drop valid for a random gap when enabled.
	task automatic send_byte(input logic [7:0] coded, input logic closes);
		if (burst_left == 0) begin
			if (sender_gaps) begin
				in_if.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		in_if.valid          <= 1'b1;
		in_if.data_byte      <= coded;
		in_if.last_of_string <= closes;
		@(posedge clk);
		while (!in_if.ready)
			@(posedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	// Encode a symbol string MSB first, pad it, optionally flip one bit,
	// and send it byte by byte.
	task automatic send_string(input int syms[$], input pad_mode_e pad_mode,
		input bit corrupt);
		bit         stream[$];
		int         pad_len;
		int         nbytes;
		int         flip_at;
		logic [7:0] coded;
		foreach (syms[s])
			for (int i = HUFF_LEN[syms[s]] - 1; i >= 0; i--)
				stream.push_back(HUFF_CODE[syms[s]][i]);
		pad_len = (8 - stream.size() % 8) % 8;
		if (pad_mode == PAD_LONG)
			pad_len += 8;
		for (int i = 0; i < pad_len; i++)
			stream.push_back((pad_mode == PAD_ONES || pad_mode == PAD_LONG) ?
				1'b1 : 1'($urandom_range(0, 1)));
		if (corrupt) begin
			flip_at = $urandom_range(0, stream.size() - 1);
			stream[flip_at] = !stream[flip_at];
		end
		nbytes = stream.size() / 8;
		for (int k = 0; k < nbytes; k++) begin
			for (int i = 0; i < 8; i++)
				coded = {coded[6:0], stream[k * 8 + i]};
			send_byte(coded, (k == nbytes - 1) && (pad_mode != PAD_OPEN));
		end
	endtask

	// Mostly the short printable codes, now and then anything in the table.
	function automatic int pick_symbol();
		if ($urandom_range(0, 7) == 0)
			return $urandom_range(0, HUFF_SYMBOLS - 1);
		return $urandom_range(32, HUFF_SYMBOLS - 1);
	endfunction

	task automatic random_string(input int max_syms, output int syms[$]);
		int n;
		n = $urandom_range(1, max_syms);
		syms = {};
		repeat (n)
			syms.push_back(pick_symbol());
	endtask

	// Drop valid and hold until every owed word has come out, then let any
	// byte that owes nothing finish inside the block.
	task automatic pause_until_drained();
		in_if.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_syms.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Hand-picked bytes: field extremes, two symbols from one byte, bytes that
	// finish nothing, padding of any length, the unknown-code error, and the
	// longest codes.
	task automatic test_directed_cases();
		int syms[$];
		sender_gaps = 1'b0;
		rx_mode     = RX_ALWAYS;
		send_byte(8'h00, 1'b0);  // '0', three zero bits left over
		send_byte(8'h00, 1'b1);  // two more '0', one bit of padding dropped
		send_byte(8'hFF, 1'b0);  // nothing completes
		send_byte(8'hFF, 1'b1);  // sixteen bits of padding dropped
		// Thirty-two ones match no code: one error word, buffer cleared.
		repeat (4)
			send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		// Thirty-bit and twenty-eight-bit codes.
		syms = {10};
		send_string(syms, PAD_ONES, 1'b0);
		syms = {127};
		send_string(syms, PAD_ONES, 1'b0);
		syms = {0, 48, 127};
		send_string(syms, PAD_LONG, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7F, 1'b1);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b1);
		send_byte(8'h01, 1'b1);
		send_byte(8'hFE, 1'b1);
	endtask

	// Encoded strings with random content, now and then with random padding;
	// sender and receiver idling change from string to string, with stretches of neither.
	task automatic test_encoded_strings(input int n_bytes);
		int syms[$];
		int start;
		start = bytes_sent;
		while (bytes_sent - start < n_bytes) begin
			sender_gaps = $urandom_range(0, 2) != 0;
			rx_mode     = rx_mode_e'($urandom_range(0, 3));
			random_string(8, syms);
			send_string(syms, ($urandom_range(0, 5) == 0) ? PAD_RANDOM : PAD_ONES, 1'b0);
		end
	endtask

	// Noise and broken strings: flipped bits, open strings that run into the
	// next one, long padding, runs of ones long enough to hit the error path.
	task automatic test_broken_strings(input int n_bytes);
		int syms[$];
		int start;
		start = bytes_sent;
		while (bytes_sent - start < n_bytes) begin
			sender_gaps = $urandom_range(0, 1);
			rx_mode     = rx_mode_e'($urandom_range(0, 3));
			case ($urandom_range(0, 4))
				0: send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
				1: repeat ($urandom_range(3, 5)) send_byte(8'hFF, 1'b0);
				2: begin
					random_string(6, syms);
					send_string(syms, PAD_OPEN, 1'b0);
				end
				3: begin
					random_string(6, syms);
					send_string(syms, PAD_LONG, 1'b0);
				end
				default: begin
					random_string(6, syms);
					send_string(syms, PAD_ONES, 1'b1);
				end
			endcase
		end
	endtask

	// Back-to-back bytes against a receiver that rarely takes a word, so the
	// output queue fills and in.ready drops.
	task automatic test_output_backpressure(input int n_bytes);
		int syms[$];
		int start;
		start       = bytes_sent;
		sender_gaps = 1'b0;
		rx_mode     = RX_SLOW;
		while (bytes_sent - start < n_bytes) begin
			random_string(8, syms);
			send_string(syms, PAD_ONES, 1'b0);
		end
	endtask

	initial begin
		bytes_sent     = 0;
		burst_left     = 0;
		sender_gaps    = 1'b0;
		rx_mode        = RX_ALWAYS;
		arst_n               <= 1'b0;
		in_if.valid          <= 1'b0;
		in_if.data_byte      <= '0;
		in_if.last_of_string <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		pause_until_drained();
		test_encoded_strings(60);
		pause_until_drained();
		test_broken_strings(30);
		pause_until_drained();
		test_output_backpressure(25);
		pause_until_drained();

		if (mismatch_count == 0)
			$display("hpack_huffman_byte_decoder test passed");
		else
			$display("hpack_huffman_byte_decoder test failed");
		$finish;
	end

endmodule

`default_nettype wire
